[design/keyed_ordered_point_table_defines.svh]
// Assertion macros for the keyed ordered point table.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef KEYED_ORDERED_POINT_TABLE_DEFINES_SVH
`define KEYED_ORDERED_POINT_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define KOPT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define KOPT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define KOPT_ASSERT_NOW(label, pre, post, msg)
`define KOPT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[design/kopt_pkg.sv]
// Shared types and constants for the keyed ordered point table.
// No dependencies; used by kopt_ctrl, kopt_dp and keyed_ordered_point_table.
package kopt_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int WIDE_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [3:0] {
    FN_PUSH      = 4'd0,
    FN_REMOVE_ID = 4'd1,
    FN_REMOVE_IX = 4'd2,
    FN_FIND      = 4'd3,
    FN_READ_IX   = 4'd4,
    FN_CLEAR     = 4'd5,
    FN_CUR_RESET = 4'd6,
    FN_CUR_ADV   = 4'd7,
    FN_CUR_LOCK  = 4'd8,
    FN_CUR_READ  = 4'd9
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] point_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] ref_tag;
    logic [7:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  found_index;
    logic [31:0] entry_id;
    logic [15:0] entry_x;
    logic [15:0] entry_y;
    logic [31:0] entry_ref;
    logic [4:0]  load;
    logic [4:0]  cursor_offset;
  } out_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] tag;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

[design/kopt_ctrl.sv]
// Controller for the keyed ordered point table: accept, execute, strobe.
// Depends on kopt_pkg (state_t, ctrl_cmd_t).
module kopt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output kopt_pkg::ctrl_cmd_t cmd
);

  kopt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kopt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == kopt_pkg::ST_EXEC);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kopt_pkg::ST_IDLE: begin
        if (start) state_nxt = kopt_pkg::ST_EXEC;
      end
      kopt_pkg::ST_EXEC: begin
        state_nxt = kopt_pkg::ST_IDLE;
      end
      default: state_nxt = kopt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    busy        = 1'b0;
    unique case (state_r)
      kopt_pkg::ST_IDLE: begin
        cmd.capture = start;
      end
      kopt_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        busy     = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[design/kopt_dp.sv]
// Datapath for the keyed ordered point table: entry registers, id compare,
// compacting shift, cursor and capacity. Depends on kopt_pkg.
module kopt_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kopt_pkg::ctrl_cmd_t        cmd,
  input  kopt_pkg::in_item_t         in_item,
  input  logic                       cfg_we,
  input  logic [kopt_pkg::CAP_W-1:0] cfg_data,
  output kopt_pkg::out_item_t        out_item
);

  kopt_pkg::in_item_t             in_r;
  kopt_pkg::out_item_t            out_r, out_nxt;
  kopt_pkg::entry_t               entries_r   [kopt_pkg::SLOTS];
  kopt_pkg::entry_t               entries_nxt [kopt_pkg::SLOTS];
  kopt_pkg::entry_t               rd_entry;
  logic [kopt_pkg::CNT_W-1:0]     count_r, count_nxt, cnt_rm, cnt_pre, cpos_m1;
  logic [kopt_pkg::CNT_W-1:0]     cpos_r, cpos_nxt;
  logic                           locked_r, locked_nxt;
  logic [kopt_pkg::CAP_W-1:0]     cap_r;
  logic [kopt_pkg::SLOTS-1:0]     hit_vec;
  logic                           hit;
  logic [kopt_pkg::IDX_W-1:0]     where;
  logic [kopt_pkg::IDX_W-1:0]     rm_idx, rd_idx;
  logic                           rm_en, push_en, rd_en, clear_en;
  logic                           cur_rst, cur_adv, cur_lock;
  logic                           ok;
  logic [kopt_pkg::IDX_W-1:0]     found;
  logic                           idx_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cpos_r   <= '0;
      locked_r <= 1'b1;
      cap_r    <= kopt_pkg::CAP_RESET;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.exec) begin
        count_r  <= count_nxt;
        cpos_r   <= cpos_nxt;
        locked_r <= locked_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_item;
    if (cmd.exec) begin
      out_r <= out_nxt;
      for (int i = 0; i < kopt_pkg::SLOTS; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
    end
  end

  // Parallel id compare over the live entries; lowest position wins.
  always_comb begin
    for (int i = 0; i < kopt_pkg::SLOTS; i++) begin
      hit_vec[i] = (kopt_pkg::CNT_W'(i) < count_r) && (entries_r[i].id == in_r.point_id);
    end
    hit   = |hit_vec;
    where = '0;
    for (int i = kopt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) where = kopt_pkg::IDX_W'(i);
    end
  end

  assign idx_ok  = kopt_pkg::WIDE_W'(in_r.slot_index) < kopt_pkg::WIDE_W'(count_r);
  assign cnt_pre = count_r - kopt_pkg::CNT_W'(hit);
  assign cpos_m1 = cpos_r - kopt_pkg::CNT_W'(1);

  // Operation decode.
  always_comb begin
    rm_en    = 1'b0;
    rm_idx   = '0;
    push_en  = 1'b0;
    rd_en    = 1'b0;
    rd_idx   = '0;
    clear_en = 1'b0;
    cur_rst  = 1'b0;
    cur_adv  = 1'b0;
    cur_lock = 1'b0;
    ok       = 1'b0;
    found    = '0;
    unique case (in_r.func)
      kopt_pkg::FN_PUSH: begin
        rm_en   = hit;
        rm_idx  = where;
        push_en = (kopt_pkg::WIDE_W'(cnt_pre) < kopt_pkg::WIDE_W'(cap_r)) &&
                  (kopt_pkg::WIDE_W'(cnt_pre) < kopt_pkg::WIDE_W'(kopt_pkg::SLOTS));
        ok      = push_en;
      end
      kopt_pkg::FN_REMOVE_ID: begin
        rm_en  = hit;
        rm_idx = where;
        ok     = hit;
      end
      kopt_pkg::FN_REMOVE_IX: begin
        rm_en  = idx_ok;
        rm_idx = in_r.slot_index[kopt_pkg::IDX_W-1:0];
      end
      kopt_pkg::FN_FIND: begin
        ok    = hit;
        found = hit ? where : '0;
      end
      kopt_pkg::FN_READ_IX: begin
        rd_en  = idx_ok;
        rd_idx = in_r.slot_index[kopt_pkg::IDX_W-1:0];
        ok     = idx_ok;
      end
      kopt_pkg::FN_CLEAR: begin
        clear_en = 1'b1;
      end
      kopt_pkg::FN_CUR_RESET: begin
        cur_rst = 1'b1;
      end
      kopt_pkg::FN_CUR_ADV: begin
        cur_adv = !locked_r && (cpos_r < count_r);
        ok      = cur_adv;
      end
      kopt_pkg::FN_CUR_LOCK: begin
        cur_lock = 1'b1;
      end
      kopt_pkg::FN_CUR_READ: begin
        rd_en  = !locked_r && (cpos_r != '0) && (cpos_r <= count_r);
        rd_idx = cpos_m1[kopt_pkg::IDX_W-1:0];
        ok     = rd_en;
      end
      default: ok = 1'b0;
    endcase
  end

  // State update: close the gap, append, clear, move or lock the cursor.
  always_comb begin
    cnt_rm    = count_r - kopt_pkg::CNT_W'(rm_en);
    count_nxt = clear_en ? '0 : cnt_rm + kopt_pkg::CNT_W'(push_en);

    cpos_nxt   = cpos_r;
    locked_nxt = locked_r;
    if (rm_en && !locked_r && (kopt_pkg::CNT_W'(rm_idx) < cpos_r)) cpos_nxt = cpos_m1;
    if (cur_adv) cpos_nxt = cpos_r + kopt_pkg::CNT_W'(1);
    if (cur_rst) begin
      cpos_nxt   = '0;
      locked_nxt = 1'b0;
    end
    if (cur_lock) locked_nxt = 1'b1;

    for (int i = 0; i < kopt_pkg::SLOTS; i++) begin
      entries_nxt[i] = entries_r[i];
      if (rm_en && (kopt_pkg::IDX_W'(i) >= rm_idx)) begin
        entries_nxt[i] = entries_r[(i < kopt_pkg::SLOTS - 1) ? i + 1 : i];
      end
      if (push_en && (kopt_pkg::CNT_W'(i) == cnt_rm)) begin
        entries_nxt[i].id  = in_r.point_id;
        entries_nxt[i].x   = in_r.pos_x;
        entries_nxt[i].y   = in_r.pos_y;
        entries_nxt[i].tag = in_r.ref_tag;
      end
    end
  end

  // Result assembly.
  always_comb begin
    rd_entry = rd_en ? entries_r[rd_idx] : '0;
    out_nxt.ok            = ok;
    out_nxt.found_index   = 4'(found);
    out_nxt.entry_id      = rd_entry.id;
    out_nxt.entry_x       = rd_entry.x;
    out_nxt.entry_y       = rd_entry.y;
    out_nxt.entry_ref     = rd_entry.tag;
    out_nxt.load          = 5'(count_nxt);
    out_nxt.cursor_offset = (locked_nxt || (cpos_nxt > count_nxt)) ? 5'd0 : 5'(cpos_nxt);
  end

  assign out_item = out_r;

endmodule

[design/keyed_ordered_point_table.sv]
// Top level of the keyed ordered point table: controller plus datapath.
// Depends on kopt_pkg, kopt_ctrl, kopt_dp and keyed_ordered_point_table_defines.svh.
//
// An operation is taken at a clock edge with start high and busy low. The next
// cycle runs it in one step (parallel id compare over all slots, then a single
// shift that closes the gap and an append), and the cycle after that carries
// the result on out_item with out_valid high for exactly one cycle. busy is low
// again in that result cycle, so a new start is taken there; a new operation is
// not taken while one executes. The receiver cannot stall; it must take each
// result in its strobe cycle. Capacity writes on the cfg channel are taken
// whenever busy is low. Slot contents are unset after reset, which needs no
// clearing pass: only positions below the load are ever read.
`include "keyed_ordered_point_table_defines.svh"
module keyed_ordered_point_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  kopt_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output kopt_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kopt_pkg::CAP_W-1:0] cfg_data
);

  kopt_pkg::ctrl_cmd_t cmd;

  assign cfg_ready = !busy;

  kopt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  kopt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_item (out_item)
  );

  `KOPT_ASSERT_NOW(a_strobe_not_busy, out_valid, !busy, "result strobe while busy")
  `KOPT_ASSERT_NEXT(a_accept_runs, start && !busy, busy && !out_valid, "transaction not run")
  `KOPT_ASSERT_NEXT(a_exec_one_cycle, busy, out_valid && !busy, "execute did not end in a result")

endmodule

[test/tb_keyed_ordered_point_table.sv]
// Testbench for keyed_ordered_point_table: drives table commands and capacity writes,
// predicts every report with its own copy of the table and checks each report field.
// Depends on kopt_pkg and the keyed_ordered_point_table RTL.
`timescale 1ns / 100ps

module tb_keyed_ordered_point_table;
  import kopt_pkg::*;

  localparam logic [3:0] FN_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] FN_UNKNOWN_HI = 4'd15;
  localparam int unsigned ID_POOL = 24;
  localparam int unsigned DRAIN_LIMIT = 100;
  localparam int unsigned REPORT_LIMIT = 60;

  class point_table_checker;
    entry_t          slots[SLOTS];
    int unsigned     load;
    int unsigned     cursor;
    bit              locked;
    int unsigned     capacity;
    out_item_t       report_q[$];
    int unsigned     fails;
    int unsigned     shown;

    function new();
      foreach (slots[i]) slots[i] = '0;
      load = 0;
      cursor = 0;
      locked = 1;
      capacity = CAP_RESET;
      fails = 0;
      shown = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return report_q.size();
    endfunction

    function int find_id(logic [31:0] id);
      for (int i = 0; i < load; i++) begin
        if (slots[i].id == id) return i;
      end
      return -1;
    endfunction

    // Close the gap; a live cursor past the removed slot steps back.
    function void remove_slot(int unsigned idx);
      if (idx >= load) return;
      if (!locked && idx < cursor) cursor--;
      load--;
      for (int unsigned i = idx; i < load; i++) slots[i] = slots[i + 1];
    endfunction

    function void note_command(in_item_t cmd);
      out_item_t rpt;
      int where;
      int unsigned room;
      rpt = '0;
      room = (capacity > SLOTS) ? SLOTS : capacity;
      case (cmd.func)
        FN_PUSH: begin
          where = find_id(cmd.point_id);
          if (where >= 0) remove_slot(where);
          if (load < room) begin
            slots[load] = '{id: cmd.point_id, x: cmd.pos_x, y: cmd.pos_y, tag: cmd.ref_tag};
            load++;
            rpt.ok = 1'b1;
          end
        end
        FN_REMOVE_ID: begin
          where = find_id(cmd.point_id);
          if (where >= 0) begin
            remove_slot(where);
            rpt.ok = 1'b1;
          end
        end
        FN_REMOVE_IX: remove_slot(cmd.slot_index);
        FN_FIND: begin
          where = find_id(cmd.point_id);
          if (where >= 0) begin
            rpt.ok = 1'b1;
            rpt.found_index = where[3:0];
          end
        end
        FN_READ_IX: begin
          if (cmd.slot_index < load) begin
            rpt.ok = 1'b1;
            rpt.entry_id = slots[cmd.slot_index].id;
            rpt.entry_x = slots[cmd.slot_index].x;
            rpt.entry_y = slots[cmd.slot_index].y;
            rpt.entry_ref = slots[cmd.slot_index].tag;
          end
        end
        FN_CLEAR: load = 0;
        FN_CUR_RESET: begin
          cursor = 0;
          locked = 0;
        end
        FN_CUR_ADV: begin
          if (!locked && cursor < load) begin
            cursor++;
            rpt.ok = 1'b1;
          end
        end
        FN_CUR_LOCK: locked = 1;
        FN_CUR_READ: begin
          if (!locked && cursor != 0 && cursor <= load) begin
            rpt.ok = 1'b1;
            rpt.entry_id = slots[cursor - 1].id;
            rpt.entry_x = slots[cursor - 1].x;
            rpt.entry_y = slots[cursor - 1].y;
            rpt.entry_ref = slots[cursor - 1].tag;
          end
        end
        default: ;
      endcase
      rpt.load = load[4:0];
      rpt.cursor_offset = (locked || cursor > load) ? 5'd0 : cursor[4:0];
      report_q.push_back(rpt);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      fails++;
      if (shown < REPORT_LIMIT) begin
        shown++;
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) flag(what, want, got);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (report_q.size() == 0) begin
        flag("report with nothing pending, ok", 32'h0, got.ok);
        return;
      end
      want = report_q.pop_front();
      check_field("ok", want.ok, got.ok);
      check_field("found_index", want.found_index, got.found_index);
      check_field("entry_id", want.entry_id, got.entry_id);
      check_field("entry_x", want.entry_x, got.entry_x);
      check_field("entry_y", want.entry_y, got.entry_y);
      check_field("entry_ref", want.entry_ref, got.entry_ref);
      check_field("load", want.load, got.load);
      check_field("cursor_offset", want.cursor_offset, got.cursor_offset);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  point_table_checker table_chk = new();

  keyed_ordered_point_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Check reports before noting the command taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) table_chk.check_report(out_item);
      if (start && !busy) table_chk.note_command(in_item);
    end
  end

  function automatic in_item_t make_cmd(logic [3:0] func, logic [31:0] id,
                                        logic [15:0] x, logic [15:0] y,
                                        logic [31:0] tag, logic [7:0] idx);
    in_item_t cmd;
    cmd.func = func;
    cmd.point_id = id;
    cmd.pos_x = x;
    cmd.pos_y = y;
    cmd.ref_tag = tag;
    cmd.slot_index = idx;
    return cmd;
  endfunction

  function automatic in_item_t random_cmd();
    int unsigned r;
    logic [3:0] func;
    logic [31:0] id;
    logic [7:0] idx;
    r = $urandom_range(0, 99);
    if (r < 34) func = FN_PUSH;
    else if (r < 44) func = FN_REMOVE_ID;
    else if (r < 51) func = FN_REMOVE_IX;
    else if (r < 60) func = FN_FIND;
    else if (r < 69) func = FN_READ_IX;
    else if (r < 71) func = FN_CLEAR;
    else if (r < 76) func = FN_CUR_RESET;
    else if (r < 86) func = FN_CUR_ADV;
    else if (r < 89) func = FN_CUR_LOCK;
    else if (r < 97) func = FN_CUR_READ;
    else func = 4'($urandom_range(FN_UNKNOWN_LO, FN_UNKNOWN_HI));
    // Keep most ids in a small pool so finds and removals hit.
    id = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, ID_POOL - 1);
    idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, SLOTS + 1));
    return make_cmd(func, id, 16'($urandom), 16'($urandom), $urandom, idx);
  endfunction

  // Hold the command until it is taken.
  task automatic send_cmd(in_item_t cmd);
    start <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_reports();
    int unsigned waited;
    start <= 1'b0;
    @(posedge clk);
    for (waited = 0; table_chk.pending() != 0 && waited < DRAIN_LIMIT; waited++)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    table_chk.set_capacity(value);
    cfg_valid <= 1'b0;
    cfg_data <= CAP_W'($urandom);
  endtask

  task automatic run_random(int unsigned count, int unsigned idle_pct);
    for (int unsigned i = 0; i < count; i++) begin
      send_cmd(random_cmd());
      if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 3));
    end
    drain_reports();
  endtask

  task automatic run_directed();
    send_cmd(make_cmd(FN_CUR_ADV, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_READ, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_READ_IX, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_REMOVE_IX, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_PUSH, 32'd1, 16'h1234, 16'h5678, 32'ha5a5_a5a5, 8'd0));
    idle_gap(1);
    send_cmd(make_cmd(FN_PUSH, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff, 8'hff));
    send_cmd(make_cmd(FN_PUSH, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    // table is at capacity: drop this one
    send_cmd(make_cmd(FN_PUSH, 32'd7, 16'd7, 16'd7, 32'd7, 8'd0));
    // same id again: move it to the tail with new data
    send_cmd(make_cmd(FN_PUSH, 32'd1, 16'h4321, 16'h8765, 32'h5a5a_5a5a, 8'd0));
    send_cmd(make_cmd(FN_FIND, 32'hffff_ffff, 16'd0, 16'd0, 32'd0, 8'd0));
    idle_gap(2);
    send_cmd(make_cmd(FN_FIND, 32'd1, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_FIND, 32'd99, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_RESET, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_ADV, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_ADV, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_READ, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    // removal ahead of the cursor pulls it back
    send_cmd(make_cmd(FN_REMOVE_IX, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    idle_gap(3);
    send_cmd(make_cmd(FN_READ_IX, 32'd0, 16'd0, 16'd0, 32'd0, 8'd255));
    send_cmd(make_cmd(FN_REMOVE_IX, 32'd0, 16'd0, 16'd0, 32'd0, 8'd200));
    send_cmd(make_cmd(FN_REMOVE_ID, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_REMOVE_ID, 32'd55, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_ADV, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    // cursor stays past the emptied table
    send_cmd(make_cmd(FN_CLEAR, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_ADV, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_READ, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_CUR_LOCK, 32'd0, 16'd0, 16'd0, 32'd0, 8'd0));
    send_cmd(make_cmd(FN_UNKNOWN_LO, 32'd1, 16'd1, 16'd1, 32'd1, 8'd1));
    send_cmd(make_cmd(FN_UNKNOWN_HI, 32'd1, 16'd1, 16'd1, 32'd1, 8'd1));
    drain_reports();
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_capacity(CAP_W'(3));
    run_directed();

    // capacity above the table size saturates
    write_capacity(CAP_W'(31));
    run_random(260, 30);
    write_capacity(CAP_W'(16));
    run_random(260, 0);
    // zero capacity below the held load: pushes drop
    write_capacity(CAP_W'(0));
    run_random(260, 60);
    write_capacity(CAP_W'(1));
    run_random(260, 30);
    write_capacity(CAP_W'(8));
    run_random(260, 45);
    write_capacity(CAP_W'($urandom_range(2, 15)));
    run_random(260, 20);
    write_capacity(CAP_W'(31));
    run_random(260, 0);

    repeat (4) @(posedge clk);
    if (table_chk.fails == 0 && table_chk.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/kopt_pkg.sv
design/kopt_ctrl.sv
design/kopt_dp.sv
design/keyed_ordered_point_table.sv
test/tb_keyed_ordered_point_table.sv
